// File: design/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Stream field widths
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DATA_W + STAT_W + 7) / 8) * 8;

    // Action codes carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DUMP_FWD   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DUMP_BWD   = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Per-cycle move for the cell row
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_SHR,
        CMD_SHL
    } t_cell_cmd;

    // Control handed to one cell
    typedef struct packed {
        t_cell_cmd cmd;
        logic      at_tail;
        logic      at_next;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: design/deq_cell.sv
`default_nettype none

module deq_cell (
    input  wire logic                       i_clk,
    input  wire deq_pkg::t_cell_ctl         i_ctl,
    input  wire logic [deq_pkg::DATA_W-1:0] i_value,
    input  wire logic [deq_pkg::DATA_W-1:0] i_from_left,
    input  wire logic [deq_pkg::DATA_W-1:0] i_from_right,
    input  wire logic [deq_pkg::DATA_W-1:0] i_wrap,
    output logic      [deq_pkg::DATA_W-1:0] o_data,
    output logic      [deq_pkg::DATA_W-1:0] o_tail_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Pick the next entry: load, shift in from a neighbor, or hold
    always_comb begin
        n_data = r_data;
        case (i_ctl.cmd)
            CMD_LOAD: begin
                if (i_ctl.at_next) begin
                    n_data = i_value;
                end
            end
            CMD_SHR: begin
                n_data = i_from_left;
            end
            CMD_SHL: begin
                n_data = i_ctl.at_tail ? i_wrap : i_from_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Offer the entry to the back gather only from the tail cell
    assign o_data      = r_data;
    assign o_tail_data = i_ctl.at_tail ? r_data : '0;

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit entries, held in a row of
// cells with the front entry always in cell 0. Each input transfer carries an
// action on tuser (push front/back, pop front/back, dump forward/backward) and
// a value on tdata. Push and pop give one result each; a new item is taken
// every cycle as long as the result register drains. A dump of n entries gives
// n results, one per cycle while the result register drains, by rotating the
// occupied cells one place per result; input is held until the dump ends.
// Popped entries are not returned. A push into a full queue reports full and is
// dropped; a pop or dump of an empty queue reports empty. Unused action codes
// are consumed with no result. No clearing pass is needed after reset: only the
// control registers (state, direction, count, step, result valid) are cleared.
module double_ended_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [deq_pkg::IN_DATA_W-1:0] i_s_axis_tdata,  // value
    input  wire logic [deq_pkg::ACT_W-1:0]     i_s_axis_tuser,  // action
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [deq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // entry_out, status, pad
    output logic                               o_m_axis_tlast   // last
);
    import deq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state             r_state;
    logic               r_dir_back;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_step;
    logic               r_m_valid;
    logic [DATA_W-1:0]  r_m_entry;
    logic [STAT_W-1:0]  r_m_status;
    logic               r_m_last;

    logic               w_s_fire;
    logic               w_out_free;
    logic               w_dump_adv;
    logic               w_full;
    logic               w_empty;
    logic               w_last_step;
    logic [DATA_W-1:0]  w_value;
    logic [DATA_W-1:0]  w_left_in;
    logic [DATA_W-1:0]  w_back;
    t_cell_cmd          w_cmd;

    logic [DATA_W-1:0]  w_data      [DEPTH];
    logic [DATA_W-1:0]  w_tail_data [DEPTH];
    t_cell_ctl          w_ctl       [DEPTH];

    // Handshake and occupancy flags
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_dump_adv      = (r_state == ST_DUMP) && w_out_free;
    assign w_full          = (r_count == CNT_W'(DEPTH));
    assign w_empty         = (r_count == '0);
    assign w_last_step     = (CNT_W'(r_step + 1'b1) == r_count);
    assign w_value         = i_s_axis_tdata[DATA_W-1:0];

    // Gather the back entry from the tail cell
    always_comb begin
        w_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back = w_back | w_tail_data[k];
        end
    end

    // Decide the row move for this cycle
    always_comb begin
        w_cmd     = CMD_HOLD;
        w_left_in = w_value;
        if (w_s_fire) begin
            case (i_s_axis_tuser)
                ACT_PUSH_FRONT: if (!w_full)  w_cmd = CMD_SHR;
                ACT_PUSH_BACK:  if (!w_full)  w_cmd = CMD_LOAD;
                ACT_POP_FRONT:  if (!w_empty) w_cmd = CMD_SHL;
                default:        w_cmd = CMD_HOLD;
            endcase
        end else if (w_dump_adv) begin
            if (r_dir_back) begin
                w_cmd     = CMD_SHR;
                w_left_in = w_back;
            end else begin
                w_cmd = CMD_SHL;
            end
        end
    end

    // Row of cells, front entry in cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_from_left;
        logic [DATA_W-1:0] w_from_right;

        if (i == 0) begin : g_first
            assign w_from_left = w_left_in;
        end else begin : g_mid_l
            assign w_from_left = w_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_final
            assign w_from_right = w_value;
        end else begin : g_mid_r
            assign w_from_right = w_data[i+1];
        end

        assign w_ctl[i].cmd     = w_cmd;
        assign w_ctl[i].at_tail = (r_count == CNT_W'(i + 1));
        assign w_ctl[i].at_next = (r_count == CNT_W'(i));

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[i]),
            .i_value      (w_value),
            .i_from_left  (w_from_left),
            .i_from_right (w_from_right),
            .i_wrap       (w_data[0]),
            .o_data       (w_data[i]),
            .o_tail_data  (w_tail_data[i])
        );
    end

    // Sequence actions, count entries and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_dir_back <= 1'b0;
            r_count    <= '0;
            r_step     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_s_fire) begin
                        r_m_entry <= '0;
                        r_m_last  <= 1'b1;
                        case (i_s_axis_tuser)
                            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                                r_m_valid <= 1'b1;
                                if (w_full) begin
                                    r_m_status <= STAT_FULL;
                                end else begin
                                    r_m_status <= STAT_OK;
                                    r_count    <= CNT_W'(r_count + 1'b1);
                                end
                            end
                            ACT_POP_FRONT, ACT_POP_BACK: begin
                                r_m_valid <= 1'b1;
                                if (w_empty) begin
                                    r_m_status <= STAT_EMPTY;
                                end else begin
                                    r_m_status <= STAT_OK;
                                    r_count    <= CNT_W'(r_count - 1'b1);
                                end
                            end
                            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
                                if (w_empty) begin
                                    r_m_valid  <= 1'b1;
                                    r_m_status <= STAT_EMPTY;
                                end else begin
                                    r_state    <= ST_DUMP;
                                    r_step     <= '0;
                                    r_dir_back <= (i_s_axis_tuser == ACT_DUMP_BWD);
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DUMP: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_entry  <= r_dir_back ? w_back : w_data[0];
                        r_m_status <= STAT_OK;
                        r_m_last   <= w_last_step;
                        r_step     <= CNT_W'(r_step + 1'b1);
                        if (w_last_step) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the result stream
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_m_status, r_m_entry});

endmodule

`default_nettype wire

// File: verif/deq_checker.sv
// Watches both stream channels of the deque, keeps a circular shadow copy of
// the queue contents, and compares every result transfer with the oldest
// outstanding prediction.
module deq_checker
    import deq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // value
    input  wire logic [ACT_W-1:0]      i_s_tuser,   // action
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,   // entry_out, status, pad
    input  wire logic                  i_m_tlast,   // last
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] entry;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_deq_result;

    // Shadow deque state
    logic [DATA_W-1:0] shadow_slots [DEPTH];
    logic [IDX_W-1:0]  shadow_head;
    logic [CNT_W-1:0]  shadow_fill;

    // Results predicted but not yet seen on the output channel
    t_deq_result pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_deq_result make_result(input logic [DATA_W-1:0] entry,
                                                input logic [STAT_W-1:0] status,
                                                input logic last);
        t_deq_result res;
        res.entry  = entry;
        res.status = status;
        res.last   = last;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns deque mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // Apply one action to the shadow deque and queue up what it should produce
    task automatic predict_action(input logic [ACT_W-1:0] act,
                                  input logic [DATA_W-1:0] val);
        int off;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (shadow_fill == DEPTH) begin
                    pending_results.push_back(make_result('0, STAT_FULL, 1'b1));
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        shadow_head = IDX_W'((shadow_head + DEPTH - 1) % DEPTH);
                        shadow_slots[shadow_head] = val;
                    end else begin
                        shadow_slots[IDX_W'((shadow_head + shadow_fill) % DEPTH)] = val;
                    end
                    shadow_fill++;
                    pending_results.push_back(make_result('0, STAT_OK, 1'b1));
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (shadow_fill == 0) begin
                    pending_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
                end else begin
                    if (act == ACT_POP_FRONT)
                        shadow_head = IDX_W'((shadow_head + 1) % DEPTH);
                    shadow_fill--;
                    pending_results.push_back(make_result('0, STAT_OK, 1'b1));
                end
            end
            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
                if (shadow_fill == 0) begin
                    pending_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        off = (act == ACT_DUMP_FWD) ? i : shadow_fill - 1 - i;
                        pending_results.push_back(make_result(
                            shadow_slots[IDX_W'((shadow_head + off) % DEPTH)], STAT_OK,
                            i == shadow_fill - 1));
                    end
                end
            end
            default: ;  // spare codes are swallowed with no result
        endcase
    endtask

    // Score result transfers first, then predict from the input transfer
    always @(posedge i_clk) begin
        t_deq_result got;
        t_deq_result want;
        if (!i_rst_n) begin
            shadow_head = '0;
            shadow_fill = '0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = make_result(i_m_tdata[DATA_W-1:0],
                                  i_m_tdata[DATA_W+STAT_W-1:DATA_W], i_m_tlast);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result entry=%0d status=%0d last=%0b",
                        $signed(got.entry), got.status, got.last));
                end else begin
                    want = pending_results.pop_front();
                    if (got.entry !== want.entry)
                        report_mismatch($sformatf("entry_out %0d, predicted %0d",
                            $signed(got.entry), $signed(want.entry)));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                            got.status, want.status));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b, predicted %0b",
                            got.last, want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_action(i_s_tuser, i_s_tdata[DATA_W-1:0]);
        end
        o_pending <= pending_results.size();
    end

endmodule

// File: verif/tb_double_ended_queue.sv
// Stimulus and verdict for the double-ended queue; scoring lives in deq_checker.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Spare action codes the block must swallow silently
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 445;
    localparam int PAUSE_AT     = 250;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 370;
    localparam int TAIL_CYCLES  = 40;
    localparam int QUIET_LIMIT  = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // value
    logic [ACT_W-1:0]      i_s_axis_tuser;   // action
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // entry_out, status, pad
    logic                  o_m_axis_tlast;   // last

    int fail_count;
    int pending;
    int accepted_items = 0;
    int quiet_cycles   = 0;
    logic hold_done    = 1'b0;

    logic [DATA_W-1:0] corner_values [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

    double_ended_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    deq_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tlast    (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic calm_window();
        return accepted_items >= CALM_FROM && accepted_items < CALM_TO;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort when neither channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_double_ended_queue failed");
            $finish;
        end
    end

    // Result side: random backpressure plus one long hold-off
    initial begin
        i_m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && accepted_items >= HOLD_AT) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_m_axis_tready <= calm_window() || ($urandom_range(99) >= 13);
                @(posedge i_clk);
            end
        end
    end

    // Offer one item after an optional random gap; return at its accepting edge
    task automatic offer(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
        while (!calm_window() && $urandom_range(99) < 13) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        accepted_items++;
    endtask

    // Stop offering until every predicted result has been received
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int mode;
        int seg_left;
        int roll;
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] val;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= ACT_PUSH_FRONT;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: pops and dumps report empty; spare codes do nothing
        offer(ACT_POP_FRONT, 32'h0);
        offer(ACT_POP_BACK, 32'hffff_ffff);
        offer(ACT_DUMP_FWD, 32'h0);
        offer(ACT_DUMP_BWD, 32'h0);
        offer(ACT_SPARE_LO, 32'h1234_5678);
        offer(ACT_SPARE_HI, 32'hffff_ffff);

        // Fill to the brim from both ends, corner values first
        for (int i = 0; i < DEPTH; i++)
            offer(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                  (i < 4) ? corner_values[2'(i)] : $urandom);

        // Full queue: pushes are dropped; dump both ways, then pop each end
        offer(ACT_PUSH_FRONT, 32'h5555_5555);
        offer(ACT_PUSH_BACK, 32'haaaa_aaaa);
        offer(ACT_DUMP_FWD, 32'h0);
        offer(ACT_DUMP_BWD, 32'h0);
        offer(ACT_POP_FRONT, 32'h0);
        offer(ACT_POP_BACK, 32'h0);

        // Random walk in segments that lean toward filling, draining or neither
        seg_left = 0;
        mode     = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(2);
                seg_left = $urandom_range(40, 10);
            end
            seg_left--;
            if (n == PAUSE_AT)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < 3)
                act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            else if (roll < 11)
                act = $urandom_range(1) ? ACT_DUMP_BWD : ACT_DUMP_FWD;
            else if ($urandom_range(99) < ((mode == 0) ? 75 : (mode == 1) ? 25 : 50))
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            val = ($urandom_range(7) == 0) ? corner_values[2'($urandom_range(3))]
                                           : $urandom;
            offer(act, val);
        end

        // Drain, let the block settle, then give the verdict
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_double_ended_queue passed");
        else
            $display("tb_double_ended_queue failed");
        $finish;
    end

endmodule
